### sv/buddy_block_allocator_top_assert.svh
// Assertion macros for the buddy block allocator
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define BBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("buddy allocator check failed");
`define BBA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("buddy allocator check failed");
`else
`define BBA_ASSERT_IMP(lbl, ante, cons)
`define BBA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### sv/bba_pkg.sv
`default_nettype none
package bba_pkg;

  localparam int MAX_ORDERS  = 10;
  localparam int BLOCK_COUNT = 512;
  localparam int IDX_W       = $clog2(BLOCK_COUNT);
  localparam int ORD_W       = $clog2(MAX_ORDERS + 1);
  localparam int LIDX_W      = $clog2(MAX_ORDERS);
  localparam int ADDR_W      = 48;
  localparam int SIZE_W      = 32;
  localparam int MORD_W      = 6;
  localparam int CFG_IDX_W   = 2;
  localparam logic [MORD_W-1:0] MIN_FLOOR = 6'd15;
  localparam logic [ADDR_W-1:0] HEAP_SIZE_RST = 48'd16777216;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOG2  = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOSPACE = 2'd1,
    STAT_RANGE   = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_EVAL, ST_DECIDE,
    ST_SP_SEL, ST_SP_RD, ST_SP_WR, ST_SP_LO, ST_SP_HI,
    ST_TK_SEL, ST_TK_RD, ST_TK_WR, ST_TK_FIN,
    ST_F_CHK, ST_MG_TEST, ST_MG_CHK, ST_MG_RD, ST_MG_WR, ST_MG_UP,
    ST_F_FIN, ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_EVAL,
    OP_SEL_SPLIT, OP_REM_RD, OP_REM_WR, OP_SPLIT_LO, OP_SPLIT_HI,
    OP_SEL_TAKE, OP_TAKE_FIN,
    OP_RD_BLK, OP_FREE_DUP, OP_FREE_ORD, OP_RD_BUD, OP_SEL_MERGE, OP_MERGE_UP,
    OP_FREE_FIN, OP_ALLOC_FAIL, OP_FREE_ERR, OP_PUSH
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept_in;
  } ctl_t;

  typedef struct packed {
    logic cfg_hit;
    logic clr_last;
    logic is_free_cmd;
    logic alloc_fail;
    logic free_err;
    logic j_gt_k;
    logic blk_free;
    logic can_merge;
    logic merge_ok;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

### sv/bba_ctrl.sv
`default_nettype none
module bba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire bba_pkg::dp_stat_t stat,
  output bba_pkg::ctl_t          ctl,
  output bba_pkg::state_t        state
);

  bba_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::ST_CLEAR:   if (stat.clr_last) state_next = bba_pkg::ST_IDLE;
      bba_pkg::ST_IDLE:    if (in_valid) state_next = bba_pkg::ST_EVAL;
      bba_pkg::ST_EVAL:    state_next = bba_pkg::ST_DECIDE;
      bba_pkg::ST_DECIDE: begin
        priority if (stat.is_free_cmd) begin
          state_next = stat.free_err ? bba_pkg::ST_DONE : bba_pkg::ST_F_CHK;
        end else if (stat.alloc_fail) begin
          state_next = bba_pkg::ST_DONE;
        end else if (stat.j_gt_k) begin
          state_next = bba_pkg::ST_SP_SEL;
        end else begin
          state_next = bba_pkg::ST_TK_SEL;
        end
      end
      bba_pkg::ST_SP_SEL:  state_next = bba_pkg::ST_SP_RD;
      bba_pkg::ST_SP_RD:   state_next = bba_pkg::ST_SP_WR;
      bba_pkg::ST_SP_WR:   state_next = bba_pkg::ST_SP_LO;
      bba_pkg::ST_SP_LO:   state_next = bba_pkg::ST_SP_HI;
      bba_pkg::ST_SP_HI:   state_next = stat.j_gt_k ? bba_pkg::ST_SP_SEL : bba_pkg::ST_TK_SEL;
      bba_pkg::ST_TK_SEL:  state_next = bba_pkg::ST_TK_RD;
      bba_pkg::ST_TK_RD:   state_next = bba_pkg::ST_TK_WR;
      bba_pkg::ST_TK_WR:   state_next = bba_pkg::ST_TK_FIN;
      bba_pkg::ST_TK_FIN:  state_next = bba_pkg::ST_DONE;
      bba_pkg::ST_F_CHK:   state_next = stat.blk_free ? bba_pkg::ST_DONE : bba_pkg::ST_MG_TEST;
      bba_pkg::ST_MG_TEST: state_next = stat.can_merge ? bba_pkg::ST_MG_CHK : bba_pkg::ST_F_FIN;
      bba_pkg::ST_MG_CHK:  state_next = stat.merge_ok ? bba_pkg::ST_MG_RD : bba_pkg::ST_F_FIN;
      bba_pkg::ST_MG_RD:   state_next = bba_pkg::ST_MG_WR;
      bba_pkg::ST_MG_WR:   state_next = bba_pkg::ST_MG_UP;
      bba_pkg::ST_MG_UP:   state_next = bba_pkg::ST_MG_TEST;
      bba_pkg::ST_F_FIN:   state_next = bba_pkg::ST_DONE;
      bba_pkg::ST_DONE:    if (!stat.out_busy) state_next = bba_pkg::ST_IDLE;
      default:             state_next = bba_pkg::ST_CLEAR;
    endcase
    if (stat.cfg_hit) state_next = bba_pkg::ST_CLEAR;
  end

  always_comb begin
    ctl.op        = bba_pkg::OP_NONE;
    ctl.accept_in = 1'b0;
    unique case (state)
      bba_pkg::ST_CLEAR: ctl.op = bba_pkg::OP_CLEAR;
      bba_pkg::ST_IDLE: begin
        ctl.accept_in = 1'b1;
        if (in_valid) ctl.op = bba_pkg::OP_LOAD;
      end
      bba_pkg::ST_EVAL: ctl.op = bba_pkg::OP_EVAL;
      bba_pkg::ST_DECIDE: begin
        priority if (stat.is_free_cmd) begin
          ctl.op = stat.free_err ? bba_pkg::OP_FREE_ERR : bba_pkg::OP_RD_BLK;
        end else if (stat.alloc_fail) begin
          ctl.op = bba_pkg::OP_ALLOC_FAIL;
        end else begin
          ctl.op = bba_pkg::OP_NONE;
        end
      end
      bba_pkg::ST_SP_SEL:  ctl.op = bba_pkg::OP_SEL_SPLIT;
      bba_pkg::ST_SP_RD:   ctl.op = bba_pkg::OP_REM_RD;
      bba_pkg::ST_SP_WR:   ctl.op = bba_pkg::OP_REM_WR;
      bba_pkg::ST_SP_LO:   ctl.op = bba_pkg::OP_SPLIT_LO;
      bba_pkg::ST_SP_HI:   ctl.op = bba_pkg::OP_SPLIT_HI;
      bba_pkg::ST_TK_SEL:  ctl.op = bba_pkg::OP_SEL_TAKE;
      bba_pkg::ST_TK_RD:   ctl.op = bba_pkg::OP_REM_RD;
      bba_pkg::ST_TK_WR:   ctl.op = bba_pkg::OP_REM_WR;
      bba_pkg::ST_TK_FIN:  ctl.op = bba_pkg::OP_TAKE_FIN;
      bba_pkg::ST_F_CHK:   ctl.op = stat.blk_free ? bba_pkg::OP_FREE_DUP : bba_pkg::OP_FREE_ORD;
      bba_pkg::ST_MG_TEST: ctl.op = stat.can_merge ? bba_pkg::OP_RD_BUD : bba_pkg::OP_NONE;
      bba_pkg::ST_MG_CHK:  ctl.op = stat.merge_ok ? bba_pkg::OP_SEL_MERGE : bba_pkg::OP_NONE;
      bba_pkg::ST_MG_RD:   ctl.op = bba_pkg::OP_REM_RD;
      bba_pkg::ST_MG_WR:   ctl.op = bba_pkg::OP_REM_WR;
      bba_pkg::ST_MG_UP:   ctl.op = bba_pkg::OP_MERGE_UP;
      bba_pkg::ST_F_FIN:   ctl.op = bba_pkg::OP_FREE_FIN;
      bba_pkg::ST_DONE:    if (!stat.out_busy) ctl.op = bba_pkg::OP_PUSH;
      default:             ctl.op = bba_pkg::OP_NONE;
    endcase
    if (stat.cfg_hit) begin
      ctl.op        = bba_pkg::OP_NONE;
      ctl.accept_in = 1'b0;
    end
  end

endmodule
`default_nettype wire

### sv/bba_dp.sv
`default_nettype none
module bba_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire bba_pkg::ctl_t                      ctl,
  output bba_pkg::dp_stat_t                       stat,
  input  wire logic                               in_cmd,
  input  wire logic [bba_pkg::SIZE_W-1:0]         in_size,
  input  wire logic [bba_pkg::ADDR_W-1:0]         in_addr,
  input  wire logic                               cfg_wr,
  input  wire logic [bba_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [bba_pkg::ADDR_W-1:0]         cfg_val,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output bba_pkg::status_t                        out_status,
  output logic [bba_pkg::ADDR_W-1:0]              out_addr
);

  localparam int IW = bba_pkg::IDX_W;
  localparam int OW = bba_pkg::ORD_W;
  localparam int AW = bba_pkg::ADDR_W;
  localparam int LW = bba_pkg::LIDX_W;
  localparam int MO = bba_pkg::MAX_ORDERS;

  logic [AW-1:0]                 heap_base;
  logic [AW-1:0]                 heap_size;
  logic [bba_pkg::MORD_W-1:0]    min_log2;
  logic [bba_pkg::MORD_W-1:0]    eff;
  logic [OW-1:0]                 num_ord;
  logic [bba_pkg::MORD_W-1:0]    eff_c;
  logic [OW-1:0]                 num_ord_c;

  logic [OW:0]     bmem [bba_pkg::BLOCK_COUNT];
  logic [IW-1:0]   nmem [bba_pkg::BLOCK_COUNT];
  logic [IW-1:0]   pmem [bba_pkg::BLOCK_COUNT];
  logic [OW:0]     bmem_q;
  logic [IW-1:0]   n_q;
  logic [IW-1:0]   p_q;

  logic [IW-1:0]   head [MO];
  logic [IW-1:0]   tail [MO];
  logic [MO-1:0]   lvalid;

  logic [IW-1:0]          clr_cnt;
  logic                   cmd_r;
  logic [bba_pkg::SIZE_W-1:0] size_r;
  logic [AW-1:0]          addr_r;
  logic [OW-1:0]          k_r;
  logic [OW-1:0]          j_r;
  logic                   fail_r;
  logic                   err_r;
  logic [IW-1:0]          cur_idx;
  logic [OW-1:0]          cur_ord;
  logic [OW-1:0]          w_ord;
  logic [IW-1:0]          w_x;
  bba_pkg::status_t       res_status;
  logic [AW-1:0]          res_addr;

  logic [OW-1:0]   k_c;
  logic [OW-1:0]   j_c;
  logic            found_c;
  logic            err_c;
  logic [AW-1:0]   off_c;
  logic [IW-1:0]   idx_c;
  logic [IW-1:0]   bud;
  logic [OW-1:0]   ord_clamp;
  logic [AW-1:0]   alloc_addr;

  logic            app_en;
  logic [OW-1:0]   app_o;
  logic [IW-1:0]   app_x;
  logic            bw_en;
  logic [IW-1:0]   bw_addr;
  logic [OW:0]     bw_data;

  always_comb begin
    logic [6:0] sh;
    logic       run;
    eff_c     = (min_log2 < bba_pkg::MIN_FLOOR) ? bba_pkg::MIN_FLOOR : min_log2;
    num_ord_c = '0;
    run       = 1'b1;
    for (int i = 0; i < MO; i++) begin
      sh  = {1'b0, eff_c} + 7'(i);
      run = run && (sh <= 7'd47) && ((49'd1 << sh) <= {1'b0, heap_size}) &&
            ((1 << i) <= bba_pkg::BLOCK_COUNT);
      if (run) num_ord_c = OW'(i + 1);
    end
  end

  always_comb begin
    logic [6:0]  sh;
    logic [6:0]  span_sh;
    logic [AW-1:0] span;
    k_c = '0;
    for (int i = 0; i < MO; i++) begin
      sh = {1'b0, eff} + 7'(i);
      if ((OW'(i) < num_ord) && (sh < 7'(bba_pkg::SIZE_W)) &&
          ((33'd1 << sh) < {1'b0, size_r})) begin
        k_c = k_c + OW'(1);
      end
    end
    j_c     = '0;
    found_c = 1'b0;
    for (int i = MO - 1; i >= 0; i--) begin
      if ((OW'(i) >= k_c) && (OW'(i) < num_ord) && lvalid[i]) begin
        j_c     = OW'(i);
        found_c = 1'b1;
      end
    end
    off_c   = addr_r - heap_base;
    span_sh = {1'b0, eff} + 7'(num_ord) - 7'd1;
    span    = AW'(1) << span_sh;
    err_c   = (num_ord == '0) || (addr_r < heap_base) || (off_c >= span);
    idx_c   = IW'(off_c >> eff);
  end

  assign bud        = cur_idx ^ (IW'(1) << cur_ord);
  assign ord_clamp  = (bmem_q[OW-1:0] > num_ord - OW'(1)) ? num_ord - OW'(1) : bmem_q[OW-1:0];
  assign alloc_addr = heap_base + (AW'(w_x) << eff);

  always_comb begin
    stat.cfg_hit     = cfg_wr && (cfg_idx <= bba_pkg::CFG_MIN_LOG2);
    stat.clr_last    = (clr_cnt == '0);
    stat.is_free_cmd = cmd_r;
    stat.alloc_fail  = fail_r;
    stat.free_err    = err_r;
    stat.j_gt_k      = (j_r > k_r);
    stat.blk_free    = bmem_q[OW];
    stat.can_merge   = ({1'b0, cur_ord} + (OW+1)'(1)) < {1'b0, num_ord};
    stat.merge_ok    = bmem_q[OW] && (bmem_q[OW-1:0] == cur_ord);
    stat.out_busy    = out_valid && !out_ready;
  end

  always_comb begin
    app_en  = 1'b0;
    app_o   = w_ord;
    app_x   = w_x;
    bw_en   = 1'b0;
    bw_addr = w_x;
    bw_data = '0;
    unique case (ctl.op)
      bba_pkg::OP_CLEAR: begin
        bw_en   = 1'b1;
        bw_addr = clr_cnt;
        bw_data = (clr_cnt == '0 && num_ord != '0) ? {1'b1, num_ord - OW'(1)} : '0;
      end
      bba_pkg::OP_SPLIT_LO: begin
        app_en  = 1'b1;
        app_o   = j_r - OW'(1);
        bw_en   = 1'b1;
        bw_data = {1'b1, j_r - OW'(1)};
      end
      bba_pkg::OP_SPLIT_HI: begin
        app_en  = 1'b1;
        app_o   = j_r;
        app_x   = w_x + (IW'(1) << j_r);
        bw_en   = 1'b1;
        bw_addr = app_x;
        bw_data = {1'b1, j_r};
      end
      bba_pkg::OP_TAKE_FIN: begin
        bw_en   = 1'b1;
        bw_data = {1'b0, k_r};
      end
      bba_pkg::OP_MERGE_UP: begin
        bw_en   = 1'b1;
        bw_data = {1'b0, cur_ord};
      end
      bba_pkg::OP_FREE_FIN: begin
        app_en  = 1'b1;
        app_o   = cur_ord;
        app_x   = cur_idx;
        bw_en   = 1'b1;
        bw_addr = cur_idx;
        bw_data = {1'b1, cur_ord};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bw_en) bmem[bw_addr] <= bw_data;
    if (ctl.op == bba_pkg::OP_RD_BUD) begin
      bmem_q <= bmem[bud];
    end else if (ctl.op == bba_pkg::OP_RD_BLK) begin
      bmem_q <= bmem[cur_idx];
    end
  end

  always_ff @(posedge clk) begin
    logic [LW-1:0] ro;
    logic [LW-1:0] ao;
    ro = w_ord[LW-1:0];
    ao = app_o[LW-1:0];
    if (ctl.op == bba_pkg::OP_REM_RD) begin
      n_q <= nmem[w_x];
      p_q <= pmem[w_x];
    end
    if (app_en && lvalid[ao]) begin
      nmem[tail[ao]] <= app_x;
      pmem[app_x]    <= tail[ao];
    end
    if (ctl.op == bba_pkg::OP_REM_WR && lvalid[ro] && head[ro] != w_x && tail[ro] != w_x) begin
      nmem[p_q] <= n_q;
      pmem[n_q] <= p_q;
    end
  end

  always_ff @(posedge clk) begin
    logic [LW-1:0] ro;
    logic [LW-1:0] ao;
    ro = w_ord[LW-1:0];
    ao = app_o[LW-1:0];
    if (rst) begin
      lvalid <= '0;
    end else if (ctl.op == bba_pkg::OP_CLEAR && clr_cnt == '0) begin
      for (int i = 0; i < MO; i++) begin
        lvalid[i] <= (num_ord != '0) && (OW'(i) == num_ord - OW'(1));
        head[i]   <= '0;
        tail[i]   <= '0;
      end
    end else if (app_en) begin
      if (!lvalid[ao]) head[ao] <= app_x;
      lvalid[ao] <= 1'b1;
      tail[ao]   <= app_x;
    end else if (ctl.op == bba_pkg::OP_REM_WR && lvalid[ro]) begin
      priority if (head[ro] == w_x && tail[ro] == w_x) begin
        lvalid[ro] <= 1'b0;
      end else if (head[ro] == w_x) begin
        head[ro] <= n_q;
      end else if (tail[ro] == w_x) begin
        tail[ro] <= p_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= '0;
      heap_size <= bba_pkg::HEAP_SIZE_RST;
      min_log2  <= bba_pkg::MIN_FLOOR;
      clr_cnt   <= IW'(bba_pkg::BLOCK_COUNT - 1);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          bba_pkg::CFG_HEAP_BASE: heap_base <= cfg_val;
          bba_pkg::CFG_HEAP_SIZE: heap_size <= cfg_val;
          bba_pkg::CFG_MIN_LOG2:  min_log2  <= cfg_val[bba_pkg::MORD_W-1:0];
          default: ;
        endcase
      end
      if (stat.cfg_hit) begin
        clr_cnt <= IW'(bba_pkg::BLOCK_COUNT - 1);
      end else if (ctl.op == bba_pkg::OP_CLEAR && clr_cnt != '0) begin
        clr_cnt <= clr_cnt - IW'(1);
      end
      if (ctl.op == bba_pkg::OP_PUSH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    eff     <= eff_c;
    num_ord <= num_ord_c;
    unique case (ctl.op)
      bba_pkg::OP_LOAD: begin
        cmd_r  <= in_cmd;
        size_r <= in_size;
        addr_r <= in_addr;
      end
      bba_pkg::OP_EVAL: begin
        k_r     <= k_c;
        j_r     <= j_c;
        fail_r  <= !found_c;
        err_r   <= err_c;
        cur_idx <= idx_c;
      end
      bba_pkg::OP_SEL_SPLIT: begin
        w_ord <= j_r;
        w_x   <= head[j_r[LW-1:0]];
      end
      bba_pkg::OP_SPLIT_LO: j_r <= j_r - OW'(1);
      bba_pkg::OP_SEL_TAKE: begin
        w_ord <= k_r;
        w_x   <= head[k_r[LW-1:0]];
      end
      bba_pkg::OP_TAKE_FIN: begin
        res_status <= bba_pkg::STAT_OK;
        res_addr   <= alloc_addr;
      end
      bba_pkg::OP_FREE_ORD: cur_ord <= ord_clamp;
      bba_pkg::OP_SEL_MERGE: begin
        w_ord <= cur_ord;
        w_x   <= bud;
      end
      bba_pkg::OP_MERGE_UP: begin
        cur_idx <= cur_idx & ~(IW'(1) << cur_ord);
        cur_ord <= cur_ord + OW'(1);
      end
      bba_pkg::OP_FREE_DUP, bba_pkg::OP_FREE_FIN: begin
        res_status <= bba_pkg::STAT_OK;
        res_addr   <= '0;
      end
      bba_pkg::OP_ALLOC_FAIL: begin
        res_status <= bba_pkg::STAT_NOSPACE;
        res_addr   <= '0;
      end
      bba_pkg::OP_FREE_ERR: begin
        res_status <= bba_pkg::STAT_RANGE;
        res_addr   <= '0;
      end
      bba_pkg::OP_PUSH: begin
        out_status <= res_status;
        out_addr   <= res_addr;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### sv/buddy_block_allocator_top.sv
// Allocate splits a free block level by level down to the requested order and
// takes it, or reports no space when none fits; free merges the block with its
// free buddy level by level, and stops on an out-of-range address or an already free block.
// One command at a time: the next is taken once the result is queued;
// a result waiting on the output holds the next one.
// Reset and every configuration write to index 0, 1 or 2 start a clearing pass
// of the block table, during which no command is accepted.
`default_nettype none
`include "buddy_block_allocator_top_assert.svh"
module buddy_block_allocator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [79:0] s_tdata,   // req_size[31:0], free_address[79:32]
  input  wire logic [0:0]  s_tuser,   // cmd[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // status[1:0], block_address[49:2], zero[55:50]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  bba_pkg::ctl_t     ctl;
  bba_pkg::dp_stat_t stat;
  bba_pkg::state_t   state;
  bba_pkg::status_t  out_status;
  logic [bba_pkg::ADDR_W-1:0] out_addr;

  assign cfg_ready = 1'b1;
  assign s_tready  = ctl.accept_in;
  assign m_tdata   = {6'd0, out_addr, out_status};

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .stat     (stat),
    .ctl      (ctl),
    .state    (state)
  );

  bba_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .stat       (stat),
    .in_cmd     (s_tuser[0]),
    .in_size    (s_tdata[31:0]),
    .in_addr    (s_tdata[79:32]),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_val    (cfg_data),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (out_status),
    .out_addr   (out_addr)
  );

  `BBA_ASSERT_IMP(a_clear_blocks_input, state == bba_pkg::ST_CLEAR, !s_tready)
  `BBA_ASSERT_IMP(a_push_no_overwrite, ctl.op == bba_pkg::OP_PUSH, !m_tvalid || m_tready)
  `BBA_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

endmodule
`default_nettype wire
